/* src/riot_pkg.sv */
// riot_pkg: operation codes, bus addresses and shared types of the interval timer
// no dependencies; imported by riot_timer and riot_interval_timer_top
`default_nettype none

package riot_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        DIV_1    = 2'd0,
        DIV_8    = 2'd1,
        DIV_64   = 2'd2,
        DIV_1024 = 2'd3
    } div_sel_t;

    localparam logic [15:0] ADDR_PORT_A    = 16'h0280;
    localparam logic [15:0] ADDR_PORT_B    = 16'h0282;
    localparam logic [15:0] ADDR_TIMER     = 16'h0284;
    localparam logic [15:0] ADDR_LOAD_1    = 16'h0294;
    localparam logic [15:0] ADDR_LOAD_8    = 16'h0295;
    localparam logic [15:0] ADDR_LOAD_64   = 16'h0296;
    localparam logic [15:0] ADDR_LOAD_1024 = 16'h0297;

    localparam logic [7:0] READ_DEFAULT  = 8'hff;
    localparam logic [7:0] TIMER_RESET   = 8'hff;
    localparam logic [1:0] SUBCYCLE_MAX  = 2'd3;

    typedef struct packed {
        logic       underflow;
        logic [7:0] read_data;
    } riot_result_t;

    function automatic logic [10:0] divide_of(input div_sel_t sel);
        logic [10:0] d;
        unique case (sel)
            DIV_1:    d = 11'd1;
            DIV_8:    d = 11'd8;
            DIV_64:   d = 11'd64;
            DIV_1024: d = 11'd1024;
            default:  d = 11'd1024;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

/* src/riot_timer.sv */
// riot_timer: timer state (tick counter, prescaler, timer, underflow flag) and bus decode
// depends on riot_pkg; the result is combinational from the word being accepted
`default_nettype none

module riot_timer
    import riot_pkg::*;
#(
    parameter int unsigned TICKS_PER_CYCLE = 3
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         accept,
    input  wire logic [1:0]   func,
    input  wire logic [15:0]  address,
    input  wire logic [7:0]   write_data,
    input  wire logic [7:0]   port_a_pins,
    input  wire logic [7:0]   port_b_pins,
    output riot_result_t      result
);

    localparam logic [1:0] TICKS_LIM = TICKS_PER_CYCLE[1:0];

    logic [1:0]  subcycle_reg,  subcycle_next;
    logic [9:0]  prescale_reg,  prescale_next;
    div_sel_t    div_sel_reg,   div_sel_next;
    logic [7:0]  timer_reg,     timer_next;
    logic        underflow_reg, underflow_next;

    logic [1:0]  sub_inc;
    logic [10:0] presc_inc;
    logic [7:0]  timer_dec;
    logic [7:0]  rd;

    always_comb begin
        sub_inc   = (subcycle_reg == SUBCYCLE_MAX) ? SUBCYCLE_MAX : subcycle_reg + 2'd1;
        presc_inc = {1'b0, prescale_reg} + 11'd1;
        timer_dec = timer_reg - 8'd1;

        subcycle_next  = subcycle_reg;
        prescale_next  = prescale_reg;
        div_sel_next   = div_sel_reg;
        timer_next     = timer_reg;
        underflow_next = underflow_reg;
        rd             = 8'd0;

        unique case (func)
            OP_TICK: begin
                subcycle_next = sub_inc;
                if (sub_inc >= TICKS_LIM) begin
                    if (!underflow_reg) begin
                        subcycle_next = 2'd0;
                        if (presc_inc >= divide_of(div_sel_reg)) begin
                            prescale_next = 10'd0;
                            timer_next    = timer_dec;
                            if (timer_reg == 8'd0) begin
                                underflow_next = 1'b1;
                            end
                        end else begin
                            prescale_next = presc_inc[9:0];
                        end
                    end else begin
                        timer_next = timer_dec;
                    end
                end
            end
            OP_READ: begin
                priority if (address == ADDR_PORT_A) begin
                    rd = port_a_pins;
                end else if (address == ADDR_PORT_B) begin
                    rd = port_b_pins;
                end else if (address == ADDR_TIMER) begin
                    rd = timer_reg;
                end else begin
                    rd = READ_DEFAULT;
                end
            end
            OP_WRITE: begin
                if (address == ADDR_LOAD_1 || address == ADDR_LOAD_8 ||
                    address == ADDR_LOAD_64 || address == ADDR_LOAD_1024) begin
                    subcycle_next  = 2'd0;
                    prescale_next  = 10'd0;
                    timer_next     = write_data;
                    underflow_next = 1'b0;
                    div_sel_next   = div_sel_t'(address[1:0]);
                end
            end
            default: begin
            end
        endcase

        result.read_data = rd;
        result.underflow = underflow_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            subcycle_reg  <= 2'd0;
            prescale_reg  <= 10'd0;
            div_sel_reg   <= DIV_1024;
            timer_reg     <= TIMER_RESET;
            underflow_reg <= 1'b0;
        end else if (accept) begin
            subcycle_reg  <= subcycle_next;
            prescale_reg  <= prescale_next;
            div_sel_reg   <= div_sel_next;
            timer_reg     <= timer_next;
            underflow_reg <= underflow_next;
        end
    end

endmodule

`default_nettype wire

/* src/riot_interval_timer_top.sv */
// riot_interval_timer_top: stream wrapper of the interval timer with a registered,
// skid-buffered result channel; depends on riot_pkg and riot_timer
//
// usage:
//   each input word is one operation: a color clock tick, a bus read or a bus write,
//   with the operation code on s_tuser and the bus fields and port pins on s_tdata
//   every accepted word yields exactly one result word on m_tdata: the read byte
//   (zero for ticks and writes) and the underflow flag as it stands after the operation
//   the result is registered in the output register, or in the skid register while the
//   output is held; one word per cycle is taken and delivered while m_tready stays high
//   s_tready depends only on the skid register, never on m_tready combinationally
//   when the receiver stalls, one more word is accepted into the skid register and
//   then s_tready drops until the output drains; timer state does not advance meanwhile
//   at reset (aresetn low, synchronous) the timer loads 0xff, divide 1024 is selected,
//   the counters and underflow flag clear and both output stages empty
//   TICKS_PER_CYCLE (1 to 3) sets how many ticks make one machine cycle
`default_nettype none

module riot_interval_timer_top
    import riot_pkg::*;
#(
    parameter int unsigned TICKS_PER_CYCLE = 3
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // address[15:0], write_data, port_a_pins, port_b_pins
    input  wire logic [1:0]  s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // read_data[7:0], underflow, zero fill
);

    logic         accept;
    logic         pop;
    riot_result_t result;

    logic         out_valid_reg,  out_valid_next;
    riot_result_t out_data_reg,   out_data_next;
    logic         skid_valid_reg, skid_valid_next;
    riot_result_t skid_data_reg,  skid_data_next;

    riot_timer #(
        .TICKS_PER_CYCLE(TICKS_PER_CYCLE)
    ) u_timer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .func        (s_tuser),
        .address     (s_tdata[15:0]),
        .write_data  (s_tdata[23:16]),
        .port_a_pins (s_tdata[31:24]),
        .port_b_pins (s_tdata[39:32]),
        .result      (result)
    );

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (accept) begin
            if (!out_valid_reg || pop) begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end else if (pop) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg.underflow, out_data_reg.read_data};

endmodule

`default_nettype wire
